// ===== design/ntp_pkg.sv =====
// Package for the netmask text parser: character codes, result kinds and
// the record that carries a closed parse to the result stage. No dependencies.
`default_nettype none
package ntp_pkg;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] NO_GAP      = 4'd15;
   localparam int         V6_BITS     = 128;
   localparam int         V4_BITS     = 32;
   localparam int         V6_WORDS    = 8;
   localparam int         V4_BYTES    = 4;
   localparam logic [7:0] PREFIX_SAT  = 8'd255;

   typedef enum logic [1:0] {
      KIND_HOST = 2'd0,
      KIND_IPV4 = 2'd1,
      KIND_IPV6 = 2'd2
   } kind_type;

   typedef struct packed {
      logic colon;
      logic dot;
      logic v4_bad;
      logic v6_bad;
      logic prefix;
      logic star;
   } flags_type;

   typedef struct packed {
      flags_type        flags;
      logic [3:0][7:0]  bytes;
      logic [2:0]       count;
      logic [7:0][15:0] words;
      logic [3:0]       word_idx;
      logic [3:0]       gap_idx;
      logic [7:0]       prefix_val;
   } snap_type;

endpackage
`default_nettype wire

// ===== design/netmask_text_parser_core.sv =====
// Netmask text parser: one ASCII character per transaction, one classified
// result on the character flagged last. Depends on ntp_pkg.
//
// A character updates the parse state in the cycle it is accepted; the
// result for a last character passes the snapshot and result registers.
// One character per cycle, unless a closed parse waits on a stalled result.
// Reset (synchronous, active high) clears the parse state and both result
// stages and sets ipv6_enable to 1.
`default_nettype none
module netmask_text_parser_core
   import ntp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] ch
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,   // [63:0] addr_high, [127:64] addr_low,
                                          // [135:128] prefix_len
   output logic [1:0]        rsp_tuser    // [1:0] mask_kind
);

   logic             ipv6_en_ff;
   flags_type        flags_ff, flags_in;
   logic [3:0][7:0]  bytes_ff, bytes_in;
   logic [2:0]       count_ff, count_in;
   logic [7:0][15:0] words_ff, words_in;
   logic [3:0]       word_idx_ff, word_idx_in;
   logic [2:0]       nib_ff, nib_in;
   logic [3:0]       gap_ff, gap_in;
   logic [7:0]       prefix_ff, prefix_in;
   logic             prev_colon_ff, prev_dot_ff;

   snap_type         snap_ff, snap_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [63:0]      hi_ff, hi_in, lo_ff, lo_in;
   logic [7:0]       plen_ff, plen_in;

   logic             out_free, s1_go, accept;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_go      = s1_valid_ff & out_free;
   assign req_tready = ~s1_valid_ff | out_free;
   assign accept     = req_tvalid & req_tready;

   // character update
   always_comb begin
      logic [7:0]  c;
      logic        is_dec, is_hex;
      logic [3:0]  hv;
      logic [11:0] pv;
      logic [7:0]  db;
      logic [1:0]  bi;
      c        = req_tdata;
      is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
      is_hex   = is_dec;
      hv       = c[3:0];
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         is_hex = 1'b1;
         hv     = c[3:0] + 4'd9;
      end
      flags_in    = flags_ff;
      bytes_in    = bytes_ff;
      count_in    = count_ff;
      words_in    = words_ff;
      word_idx_in = word_idx_ff;
      nib_in      = nib_ff;
      gap_in      = gap_ff;
      prefix_in   = prefix_ff;
      pv          = 12'({4'd0, prefix_ff} * 12'd10 + {8'd0, c[3:0]});
      bi          = 2'(count_ff - 3'd1);
      db          = 8'(bytes_ff[bi] * 8'd10 + {4'd0, c[3:0]});
      if (c == CH_COLON) flags_in.colon = 1'b1;
      if (c == CH_DOT)   flags_in.dot   = 1'b1;
      if (flags_ff.star) begin
         flags_in.v4_bad = 1'b1;
         flags_in.v6_bad = 1'b1;
      end else if (flags_ff.prefix) begin
         if (is_dec) begin
            prefix_in = (pv > 12'd255) ? PREFIX_SAT : pv[7:0];
         end else begin
            flags_in.v4_bad = 1'b1;
            flags_in.v6_bad = 1'b1;
         end
      end else if (is_hex) begin
         if (!flags_ff.v6_bad) begin
            if (nib_ff == 3'd0) begin
               flags_in.v6_bad = 1'b1;
            end else begin
               words_in[word_idx_ff[2:0]] = {words_ff[word_idx_ff[2:0]][11:0], hv};
               nib_in = nib_ff - 3'd1;
            end
         end
         if (is_dec) bytes_in[bi] = db;
         else flags_in.v4_bad = 1'b1;
      end else if (c == CH_COLON) begin
         flags_in.v4_bad = 1'b1;
         if (!flags_ff.v6_bad) begin
            if (prev_colon_ff) begin
               if (gap_ff != NO_GAP) flags_in.v6_bad = 1'b1;
               else gap_in = word_idx_ff;
            end else begin
               nib_in      = 3'd4;
               word_idx_in = word_idx_ff + 4'd1;
               if (word_idx_in >= 4'd8) flags_in.v6_bad = 1'b1;
            end
         end
      end else if (c == CH_DOT) begin
         flags_in.v6_bad = 1'b1;
         if (count_ff >= 3'd4) flags_in.v4_bad = 1'b1;
         else count_in = count_ff + 3'd1;
      end else if (c == CH_STAR) begin
         flags_in.star = 1'b1;
         if (!prev_dot_ff) flags_in.v4_bad = 1'b1;
         if (gap_ff != NO_GAP || word_idx_ff == 4'd0 || !prev_colon_ff)
            flags_in.v6_bad = 1'b1;
      end else if (c == CH_SLASH) begin
         flags_in.prefix = 1'b1;
         if (!flags_ff.v6_bad) word_idx_in = word_idx_ff + 4'd1;
      end else begin
         flags_in.v4_bad = 1'b1;
         flags_in.v6_bad = 1'b1;
      end
      snap_in.flags      = flags_in;
      snap_in.bytes      = bytes_in;
      snap_in.count      = count_in;
      snap_in.words      = words_in;
      snap_in.word_idx   = word_idx_in;
      snap_in.gap_idx    = gap_in;
      snap_in.prefix_val = prefix_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv6_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         ipv6_en_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         flags_ff      <= '0;
         bytes_ff      <= '0;
         count_ff      <= 3'd1;
         words_ff      <= '0;
         word_idx_ff   <= 4'd0;
         nib_ff        <= 3'd4;
         gap_ff        <= NO_GAP;
         prefix_ff     <= 8'd0;
         prev_colon_ff <= 1'b0;
         prev_dot_ff   <= 1'b0;
      end else if (accept) begin
         flags_ff      <= flags_in;
         bytes_ff      <= bytes_in;
         count_ff      <= count_in;
         words_ff      <= words_in;
         word_idx_ff   <= word_idx_in;
         nib_ff        <= nib_in;
         gap_ff        <= gap_in;
         prefix_ff     <= prefix_in;
         prev_colon_ff <= (req_tdata == CH_COLON);
         prev_dot_ff   <= (req_tdata == CH_DOT);
      end
   end

   // hold the closed parse until the result register frees up
   assign s1_valid_in = (accept & req_tlast) | (s1_valid_ff & ~s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         snap_ff <= snap_in;
      end
   end

   // closing: expand, mask and classify
   always_comb begin
      logic [3:0]  dp;
      logic [7:0]  dp16;
      logic [8:0]  b6;
      logic        ok6, ok4, has_gap;
      logic [3:0]  fill, src;
      logic [4:0]  gap_end;
      logic [15:0] w [V6_WORDS];
      logic [2:0]  n;
      logic [5:0]  n8, b4;
      logic [7:0]  b [V4_BYTES];
      has_gap = (snap_ff.gap_idx != NO_GAP);
      dp      = snap_ff.flags.prefix ? snap_ff.word_idx : snap_ff.word_idx + 4'd1;
      if (dp > 4'd8) dp = 4'd8;
      dp16 = {dp, 4'd0};
      ok6  = ~snap_ff.flags.v6_bad;
      if (snap_ff.flags.prefix) begin
         b6 = {1'b0, snap_ff.prefix_val};
         if (snap_ff.prefix_val > dp16 && !(has_gap && snap_ff.prefix_val <= 8'd128))
            ok6 = 1'b0;
      end else if (snap_ff.flags.star) begin
         b6 = {1'b0, snap_ff.word_idx, 4'd0};
      end else begin
         b6 = 9'(V6_BITS);
      end
      if (!has_gap && b6 == 9'd0) b6 = {1'b0, dp16};
      fill    = 4'd8 - dp;
      gap_end = {1'b0, snap_ff.gap_idx} + {1'b0, fill};
      for (int i = 0; i < V6_WORDS; i++) begin
         src = 4'(i) - fill;
         if (has_gap) begin
            if (4'(i) < snap_ff.gap_idx)  w[i] = snap_ff.words[i];
            else if (5'(i) < gap_end)     w[i] = 16'd0;
            else                          w[i] = snap_ff.words[src[2:0]];
         end else begin
            w[i] = (4'(i) < dp) ? snap_ff.words[i] : 16'd0;
         end
         if (4'(i) == b6[7:4] && b6[3:0] != 4'd0)
            w[i] = w[i] & ~(16'hFFFF >> b6[3:0]);
         else if (4'(i) >= b6[7:4])
            w[i] = 16'd0;
      end

      n   = snap_ff.count;
      if (n < 3'd1) n = 3'd1;
      if (n > 3'd4) n = 3'd4;
      n8  = {n, 3'd0};
      ok4 = ~snap_ff.flags.v4_bad;
      if (snap_ff.flags.prefix) begin
         b4 = snap_ff.prefix_val[5:0];
         if (snap_ff.prefix_val > {2'd0, n8}) ok4 = 1'b0;
      end else if (snap_ff.flags.star) begin
         b4 = {n - 3'd1, 3'd0};
      end else begin
         b4 = 6'd0;
      end
      if (n < 3'd4 && b4 == 6'd0) b4 = n8;
      if (b4 == 6'd0) b4 = 6'(V4_BITS);
      for (int i = 0; i < V4_BYTES; i++) begin
         b[i] = (3'(i) < n) ? snap_ff.bytes[i] : 8'd0;
         if (3'(i) == b4[5:3] && b4[2:0] != 3'd0)
            b[i] = b[i] & ~(8'hFF >> b4[2:0]);
         else if (3'(i) >= b4[5:3])
            b[i] = 8'd0;
      end

      kind_in = KIND_HOST;
      hi_in   = 64'd0;
      lo_in   = 64'd0;
      plen_in = 8'd0;
      if (ipv6_en_ff && snap_ff.flags.colon) begin
         if (ok6) begin
            kind_in = KIND_IPV6;
            hi_in   = {w[0], w[1], w[2], w[3]};
            lo_in   = {w[4], w[5], w[6], w[7]};
            plen_in = b6[7:0];
         end
      end else if (snap_ff.flags.dot) begin
         if (ok4) begin
            kind_in = KIND_IPV4;
            lo_in   = {32'd0, b[0], b[1], b[2], b[3]};
            plen_in = {2'd0, b4};
         end
      end
   end

   assign rsp_valid_in = s1_go | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         kind_ff <= kind_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         plen_ff <= plen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {plen_ff, lo_ff, hi_ff};

`ifndef ASSERT_OFF
   a_host_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HOST |-> rsp_tdata == 136'd0)
      else $error("hostmask result carries nonzero payload");
   a_v4_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IPV4
         |-> rsp_tdata[63:0] == 64'd0 && rsp_tdata[127:96] == 32'd0
             && rsp_tdata[135:128] <= 8'd32 && rsp_tdata[135:128] != 8'd0)
      else $error("IPv4 result out of shape");
   a_v6_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IPV6 |-> rsp_tdata[135:128] <= 8'd128)
      else $error("IPv6 prefix too long");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while closed parse is stuck");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_netmask_text_parser_core.sv =====
// Self-checking testbench for netmask_text_parser_core: streams mask text,
// predicts each classified result and compares it field by field.
// Depends on ntp_pkg and the netmask_text_parser_core RTL.
`default_nettype none
module tb_netmask_text_parser_core;
   import ntp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_item_t;

   typedef struct {
      kind_type    kind;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [7:0]  plen;
   } mask_result_t;

   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   netmask_text_parser_core uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   char_item_t   pending_chars[$];
   mask_result_t expected_masks[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           sent_count = 0;
   bit           pace_input = 1'b1;

   // predictor state
   logic        v6_enable;
   logic [7:0]  p_bytes[4];
   logic [2:0]  p_count;
   logic [15:0] p_words[8];
   logic [3:0]  p_widx;
   logic [2:0]  p_nib;
   logic [3:0]  p_gap;
   logic [7:0]  p_prefix;
   logic        f_colon, f_dot, f_v4bad, f_v6bad, f_prefix, f_star, f_prev;
   logic [7:0]  p_prev;

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   task automatic clear_parse_state();
      for (int i = 0; i < 4; i++) p_bytes[i] = '0;
      for (int i = 0; i < 8; i++) p_words[i] = '0;
      p_count = 3'd1; p_widx = '0; p_nib = 3'd4; p_gap = NO_GAP; p_prefix = '0;
      {f_colon, f_dot, f_v4bad, f_v6bad, f_prefix, f_star, f_prev} = '0;
      p_prev = '0;
   endtask

   task automatic absorb_char(input logic [7:0] c);
      logic had_prev;
      int   hv, v, k;
      had_prev = f_prev;
      hv = hex_value(c);
      if (c == CH_COLON) f_colon = 1;
      if (c == CH_DOT) f_dot = 1;
      if (f_star) begin
         f_v4bad = 1; f_v6bad = 1;
      end else if (f_prefix) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = p_prefix * 10 + (c - CH_ZERO);
            p_prefix = (v > 255) ? PREFIX_SAT : v[7:0];
         end else begin
            f_v4bad = 1; f_v6bad = 1;
         end
      end else if (hv >= 0) begin
         if (!f_v6bad) begin
            if (p_nib == 0) f_v6bad = 1;
            else begin
               k = p_widx & 7;
               p_words[k] = {p_words[k][11:0], 4'(hv)};
               p_nib--;
            end
         end
         if (c >= CH_ZERO && c <= CH_NINE) begin
            k = (p_count - 1) & 3;
            v = p_bytes[k] * 10 + (c - CH_ZERO);
            p_bytes[k] = v[7:0];
         end else f_v4bad = 1;
      end else if (c == CH_COLON) begin
         f_v4bad = 1;
         if (!f_v6bad) begin
            if (had_prev && p_prev == CH_COLON) begin
               if (p_gap != NO_GAP) f_v6bad = 1;
               else p_gap = p_widx;
            end else begin
               p_nib = 3'd4;
               p_widx++;
               if (p_widx >= 8) f_v6bad = 1;
            end
         end
      end else if (c == CH_DOT) begin
         f_v6bad = 1;
         if (p_count >= 4) f_v4bad = 1;
         else p_count++;
      end else if (c == CH_STAR) begin
         f_star = 1;
         if (!(had_prev && p_prev == CH_DOT)) f_v4bad = 1;
         if (p_gap != NO_GAP || p_widx == 0 || !(had_prev && p_prev == CH_COLON))
            f_v6bad = 1;
      end else if (c == CH_SLASH) begin
         f_prefix = 1;
         if (!f_v6bad) p_widx++;
      end else begin
         f_v4bad = 1; f_v6bad = 1;
      end
      p_prev = c;
      f_prev = 1;
   endtask

   function automatic bit close_v6(output mask_result_t r);
      int dp, bits, fill, full;
      logic [15:0] w[8];
      if (f_v6bad) return 0;
      dp = f_prefix ? p_widx : p_widx + 1;
      if (dp > 8) dp = 8;
      if (f_prefix) begin
         bits = p_prefix;
         if (bits > dp * 16 && !(p_gap != NO_GAP && bits <= V6_BITS)) return 0;
      end else if (f_star) bits = p_widx * 16;
      else bits = V6_BITS;
      if (p_gap == NO_GAP && bits == 0) bits = dp * 16;
      if (p_gap != NO_GAP) begin
         fill = 8 - dp;
         for (int i = 0; i < 8; i++)
            if (i < p_gap) w[i] = p_words[i & 7];
            else if (i < p_gap + fill) w[i] = '0;
            else w[i] = p_words[(i - fill) & 7];
      end else
         for (int i = 0; i < 8; i++) w[i] = (i < dp) ? p_words[i] : '0;
      if (bits < V6_BITS && bits % 16 != 0)
         w[bits / 16] &= ~((17'd1 << (16 - bits % 16)) - 1);
      full = bits / 16 + ((bits % 16) ? 1 : 0);
      for (int i = full; i < 8; i++) w[i] = '0;
      r.kind = KIND_IPV6;
      r.hi = {w[0], w[1], w[2], w[3]};
      r.lo = {w[4], w[5], w[6], w[7]};
      r.plen = bits[7:0];
      return 1;
   endfunction

   function automatic bit close_v4(output mask_result_t r);
      int n, bits, full;
      logic [7:0] b[4];
      if (f_v4bad) return 0;
      n = p_count;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      if (f_prefix) begin
         bits = p_prefix;
         if (bits > n * 8) return 0;
      end else if (f_star) bits = (n - 1) * 8;
      else bits = 0;
      if (n < 4 && bits == 0) bits = n * 8;
      for (int i = 0; i < 4; i++) b[i] = (i < n) ? p_bytes[i] : '0;
      if (bits == 0) bits = V4_BITS;
      if (bits < V4_BITS && bits % 8 != 0)
         b[bits / 8] &= ~((9'd1 << (8 - bits % 8)) - 1);
      full = bits / 8 + ((bits % 8) ? 1 : 0);
      for (int i = full; i < 4; i++) b[i] = '0;
      r.kind = KIND_IPV4;
      r.hi = '0;
      r.lo = {32'd0, b[0], b[1], b[2], b[3]};
      r.plen = bits[7:0];
      return 1;
   endfunction

   task automatic predict_mask(input char_item_t it);
      mask_result_t r;
      bit ok;
      absorb_char(it.ch);
      if (!it.last) return;
      ok = 0;
      if (v6_enable && f_colon) ok = close_v6(r);
      else if (f_dot) ok = close_v4(r);
      if (!ok) begin
         r.kind = KIND_HOST; r.hi = '0; r.lo = '0; r.plen = '0;
      end
      expected_masks.push_back(r);
      clear_parse_state();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_mask('{ch: req_tdata, last: req_tlast});
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || pending_chars.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               char_item_t it;
               it = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= it.ch;
               req_tlast <= it.last;
               if (pace_input) send_gap = gap_length();
            end
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      mask_result_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_masks.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[63:0], 64'd0);
            end else begin
               want = expected_masks.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("mask_kind", 64'(rsp_tuser), 64'(want.kind));
               if (rsp_tdata[63:0] !== want.hi)
                  report_mismatch("addr_high", rsp_tdata[63:0], want.hi);
               if (rsp_tdata[127:64] !== want.lo)
                  report_mismatch("addr_low", rsp_tdata[127:64], want.lo);
               if (rsp_tdata[135:128] !== want.plen)
                  report_mismatch("prefix_len", 64'(rsp_tdata[135:128]), 64'(want.plen));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (pace_input) recv_gap = gap_length();
         end
      end
   end

   always @(posedge clock)
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end

   int queued_count = 0;

   task automatic push_text(input string s, input bit add_last = 1);
      for (int i = 0; i < s.len(); i++) begin
         pending_chars.push_back('{ch: s[i], last: (add_last && i == s.len() - 1)});
         queued_count++;
      end
   endtask

   task automatic push_raw(input logic [7:0] c, input logic l);
      pending_chars.push_back('{ch: c, last: l});
      queued_count++;
   endtask

   function automatic string dec_group();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return "";
      if (r < 7) return $sformatf("%0d", $urandom_range(0, 255));
      return $sformatf("%0d", $urandom_range(0, 99999));
   endfunction

   function automatic string hex_group();
      string s, digits;
      int n;
      digits = "0123456789abcdefABCDEF";
      s = "";
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 6) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(0, 21)])};
      return s;
   endfunction

   function automatic string tail_part(input bit v6);
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return "";
      if (r < 6) return v6 ? ":*" : ".*";
      if (r < 9) return $sformatf("/%0d", $urandom_range(0, v6 ? 130 : 34));
      return $sformatf("/%0d", $urandom_range(0, 999));
   endfunction

   function automatic string random_v4();
      string s;
      int n;
      n = $urandom_range(1, 5);
      s = dec_group();
      for (int i = 1; i < n; i++) s = {s, ".", dec_group()};
      return {s, tail_part(0)};
   endfunction

   function automatic string random_v6();
      string s;
      int n, gap_at;
      n = $urandom_range(1, 9);
      gap_at = $urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, n);
      s = "";
      for (int i = 0; i < n; i++) begin
         if (i == gap_at) s = {s, "::"};
         else if (i > 0) s = {s, ":"};
         s = {s, hex_group()};
      end
      if (gap_at == n) s = {s, "::"};
      return {s, tail_part(1)};
   endfunction

   function automatic string random_noise();
      string s, pool;
      int n;
      pool = "0123456789abcdefxyzG.:/*-_ ";
      n = $urandom_range(1, 12);
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
      return s;
   endfunction

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_tvalid || expected_masks.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_v6_enable(input logic val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      v6_enable = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int r;
      string s;
      v6_enable = 1'b1;
      clear_parse_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, both parsers, stars, slashes, rejects
      push_text("255.255.255.255");
      push_text("10.1.*");
      push_text("1.2.3.4/0");
      push_text("ff::/");
      push_text("1:2:3:4:5:6:7:8");
      push_text("fe80:1:*");
      push_text("12345.0/999");
      push_raw(8'h00, 1'b1);
      push_raw(8'hFF, 1'b1);
      push_raw(8'h80, 1'b0);
      push_raw(8'h7F, 1'b1);
      push_text("1/2/3");
      wait_drained();

      write_v6_enable(1'b0);
      push_text("a:b::c/40");
      push_text("1.2.3/20");
      wait_drained();
      write_v6_enable(1'b1);

      pace_input = 1'b1;
      while (queued_count < 1850) begin
         r = $urandom_range(0, 99);
         if (r < 42) s = random_v4();
         else if (r < 84) s = random_v6();
         else s = random_noise();
         if (queued_count > 900 && queued_count < 1000) pace_input = 1'b0;
         else pace_input = 1'b1;
         if ($urandom_range(0, 40) == 0) push_raw(8'($urandom_range(0, 255)), 1'b1);
         else push_text(s);
         if (queued_count > 600 && queued_count < 620) begin
            wait_drained();
            write_v6_enable(1'b0);
         end else if (queued_count > 1300 && queued_count < 1330) begin
            wait_drained();
            write_v6_enable(1'b1);
         end
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/ntp_pkg.sv
design/netmask_text_parser_core.sv
tb/tb_netmask_text_parser_core.sv
